/* sv/pse_pkg.sv */
// Package with the types, constants and control program of the pointer speed estimator.
`default_nettype none
package pse_pkg;

  localparam int unsigned SCALE_W = 10;
  localparam int unsigned MAXIN_W = 15;
  localparam int unsigned CFG_DATA_W = 15;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned STEP_W = 4;

  localparam logic [CFG_IDX_W-1:0] CFG_SPEED_SCALE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_INPUT = 1'b1;

  localparam logic [SCALE_W-1:0] SPEED_SCALE_RESET = 10'd10;
  localparam logic [MAXIN_W-1:0] MAX_INPUT_RESET = 15'd1000;

  localparam logic [9:0] MS_PER_SECOND = 10'd1000;
  localparam logic [9:0] EMA_OLD_WEIGHT = 10'd700;
  localparam logic [9:0] EMA_NEW_WEIGHT = 10'd300;
  localparam logic [9:0] EMA_TOTAL = 10'd1000;

  // Dividing by 1000 is a shift right by three and a multiply by the rounded-up
  // reciprocal of 125 scaled by two to the thirtieth.
  localparam logic [23:0] EMA_RECIP = 24'd8589935;
  localparam int unsigned EMA_RECIP_SHIFT = 30;

  localparam logic [4:0] DIV_LAST = 5'd25;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_ACCEPT,
    OP_MUL_SCALE,
    OP_DIV_LOAD_INST,
    OP_DIV_STEP,
    OP_INST_QUO,
    OP_INST_PROD,
    OP_EMA_MUL,
    OP_EMA_SUM,
    OP_EMA_RECIP,
    OP_EMIT_AVG,
    OP_EMIT_SEED
  } op_t;

  typedef enum logic [2:0] {
    COND_NEXT,
    COND_ALWAYS,
    COND_SEED,
    COND_OUT_RANGE,
    COND_DIV_BUSY
  } cond_t;

  typedef struct packed {
    op_t              op;
    cond_t            cond;
    logic [STEP_W-1:0] target;
  } ucode_t;

  localparam logic [STEP_W-1:0] ST_ACCEPT = 4'd0;
  localparam logic [STEP_W-1:0] ST_MUL = 4'd1;
  localparam logic [STEP_W-1:0] ST_TEST_SEED = 4'd2;
  localparam logic [STEP_W-1:0] ST_TEST_RANGE = 4'd3;
  localparam logic [STEP_W-1:0] ST_DIV_INST = 4'd4;
  localparam logic [STEP_W-1:0] ST_STEP_INST = 4'd5;
  localparam logic [STEP_W-1:0] ST_INST_QUO = 4'd6;
  localparam logic [STEP_W-1:0] ST_INST_PROD = 4'd7;
  localparam logic [STEP_W-1:0] ST_EMA_MUL = 4'd8;
  localparam logic [STEP_W-1:0] ST_EMA_SUM = 4'd9;
  localparam logic [STEP_W-1:0] ST_EMA_RECIP = 4'd10;
  localparam logic [STEP_W-1:0] ST_EMIT_AVG = 4'd11;
  localparam logic [STEP_W-1:0] ST_EMIT_SEED = 4'd12;

  function automatic ucode_t ucode_rom(input logic [STEP_W-1:0] step);
    ucode_t w;
    w = '{op: OP_NOP, cond: COND_ALWAYS, target: ST_ACCEPT};
    unique case (step)
      ST_ACCEPT:     w = '{op: OP_ACCEPT,        cond: COND_NEXT,      target: ST_ACCEPT};
      ST_MUL:        w = '{op: OP_MUL_SCALE,     cond: COND_NEXT,      target: ST_ACCEPT};
      ST_TEST_SEED:  w = '{op: OP_NOP,           cond: COND_SEED,      target: ST_EMIT_SEED};
      ST_TEST_RANGE: w = '{op: OP_NOP,           cond: COND_OUT_RANGE, target: ST_INST_PROD};
      ST_DIV_INST:   w = '{op: OP_DIV_LOAD_INST, cond: COND_NEXT,      target: ST_ACCEPT};
      ST_STEP_INST:  w = '{op: OP_DIV_STEP,      cond: COND_DIV_BUSY,  target: ST_STEP_INST};
      ST_INST_QUO:   w = '{op: OP_INST_QUO,      cond: COND_ALWAYS,    target: ST_EMA_MUL};
      ST_INST_PROD:  w = '{op: OP_INST_PROD,     cond: COND_NEXT,      target: ST_ACCEPT};
      ST_EMA_MUL:    w = '{op: OP_EMA_MUL,       cond: COND_NEXT,      target: ST_ACCEPT};
      ST_EMA_SUM:    w = '{op: OP_EMA_SUM,       cond: COND_NEXT,      target: ST_ACCEPT};
      ST_EMA_RECIP:  w = '{op: OP_EMA_RECIP,     cond: COND_NEXT,      target: ST_ACCEPT};
      ST_EMIT_AVG:   w = '{op: OP_EMIT_AVG,      cond: COND_ALWAYS,    target: ST_ACCEPT};
      ST_EMIT_SEED:  w = '{op: OP_EMIT_SEED,     cond: COND_ALWAYS,    target: ST_ACCEPT};
      default:       w = '{op: OP_NOP,           cond: COND_ALWAYS,    target: ST_ACCEPT};
    endcase
    return w;
  endfunction

endpackage
`default_nettype wire

/* sv/pse_in_if.sv */
// Input channel carrying one pointer movement event per transaction.
`default_nettype none
interface pse_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] movement;
  logic        [31:0] now_ms;

  modport source (output valid, output movement, output now_ms, input ready);
  modport sink (input valid, input movement, input now_ms, output ready);
endinterface
`default_nettype wire

/* sv/pse_out_if.sv */
// Result channel carrying one smoothed speed estimate per transaction.
`default_nettype none
interface pse_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] speed;

  modport source (output valid, output speed, input ready);
  modport sink (input valid, input speed, output ready);
endinterface
`default_nettype wire

/* sv/pointer_speed_estimator.sv */
// Microcoded pointer speed estimator with an iterative divider for the instantaneous speed.
// One event is processed at a time: the 26-step divider runs only for a delta of 1 to
// 999 ms, and the next event is taken while the previous result still waits in the output
// register.
// Synchronous active-low reset restores the register defaults and clears time and average.
`default_nettype none
module pointer_speed_estimator
  import pse_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  pse_in_if.sink                     in_ch,
  pse_out_if.source                  out_ch,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  logic [STEP_W-1:0]  step_r, step_nxt;
  logic [SCALE_W-1:0] scale_r;
  logic [MAXIN_W-1:0] maxin_r;
  logic [14:0]        mag_r;
  logic [31:0]        now_r;
  logic [31:0]        last_r;
  logic [15:0]        avg_r;
  logic [24:0]        prod_r;
  logic [15:0]        inst_r;
  logic [25:0]        pa_r;
  logic [24:0]        pb_r;
  logic [25:0]        quo_r;
  logic [9:0]         rem_r;
  logic [9:0]         div_r;
  logic [4:0]         cnt_r;
  logic [15:0]        ema_quo_r;
  logic               out_valid_r;
  logic [15:0]        out_speed_r;

  ucode_t      uw;
  logic [16:0] abs_mv;
  logic [14:0] mag_clamp;
  logic [31:0] delta;
  logic        seed;
  logic        in_range;
  logic        out_free;
  logic        stall;
  logic        take;
  logic [11:0] diff;
  logic [25:0] mag_k;
  logic [25:0] ema_sum;
  logic [45:0] ema_recip;
  logic [15:0] sat_prod;
  logic [15:0] sat_quo;

  assign uw = ucode_rom(step_r);

  assign abs_mv = in_ch.movement[15] ? 17'(17'h10000 - {1'b0, in_ch.movement})
                                     : {1'b0, in_ch.movement};
  assign mag_clamp = (abs_mv > {2'b00, maxin_r}) ? maxin_r : abs_mv[14:0];

  assign delta    = now_r - last_r;
  assign seed     = (last_r == 32'd0) || (now_r < last_r);
  assign in_range = (delta != 32'd0) && (delta < {22'd0, MS_PER_SECOND});

  assign out_free = !out_valid_r || out_ch.ready;
  assign stall    = ((uw.op == OP_ACCEPT) && !in_ch.valid) ||
                    (((uw.op == OP_EMIT_AVG) || (uw.op == OP_EMIT_SEED)) && !out_free);
  assign take     = in_ch.valid && in_ch.ready;

  assign in_ch.ready  = (uw.op == OP_ACCEPT);
  assign out_ch.valid = out_valid_r;
  assign out_ch.speed = out_speed_r;

  assign diff      = {1'b0, rem_r, quo_r[25]} - {2'b00, div_r};
  assign mag_k     = {11'd0, mag_r} * {16'd0, MS_PER_SECOND};
  assign ema_sum   = pa_r + {1'b0, pb_r};
  assign ema_recip = {23'd0, quo_r[25:3]} * {22'd0, EMA_RECIP};
  assign sat_prod  = (|prod_r[24:16]) ? 16'hFFFF : prod_r[15:0];
  assign sat_quo   = (|quo_r[25:16]) ? 16'hFFFF : quo_r[15:0];

  always_comb begin
    step_nxt = step_r;
    if (!stall) begin
      unique case (uw.cond)
        COND_NEXT:      step_nxt = 4'(step_r + 4'd1);
        COND_ALWAYS:    step_nxt = uw.target;
        COND_SEED:      step_nxt = seed ? uw.target : 4'(step_r + 4'd1);
        COND_OUT_RANGE: step_nxt = !in_range ? uw.target : 4'(step_r + 4'd1);
        COND_DIV_BUSY:  step_nxt = (cnt_r != 5'd0) ? uw.target : 4'(step_r + 4'd1);
        default:        step_nxt = ST_ACCEPT;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= ST_ACCEPT;
      scale_r     <= SPEED_SCALE_RESET;
      maxin_r     <= MAX_INPUT_RESET;
      last_r      <= 32'd0;
      avg_r       <= 16'd0;
      out_valid_r <= 1'b0;
    end else begin
      step_r <= step_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_SPEED_SCALE: scale_r <= cfg_data[SCALE_W-1:0];
          CFG_MAX_INPUT:   maxin_r <= cfg_data[MAXIN_W-1:0];
          default: ;
        endcase
      end
      if (!stall && ((uw.op == OP_EMIT_AVG) || (uw.op == OP_EMIT_SEED))) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      if (!stall) begin
        case (uw.op)
          OP_EMIT_AVG: begin
            avg_r  <= ema_quo_r;
            last_r <= now_r;
          end
          OP_EMIT_SEED: begin
            avg_r  <= sat_prod;
            last_r <= now_r;
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!stall) begin
      case (uw.op)
        OP_ACCEPT: begin
          mag_r <= mag_clamp;
          now_r <= in_ch.now_ms;
        end
        OP_MUL_SCALE: prod_r <= 25'({10'd0, mag_r} * {15'd0, scale_r});
        OP_DIV_LOAD_INST: begin
          quo_r <= mag_k;
          rem_r <= 10'd0;
          div_r <= delta[9:0];
          cnt_r <= DIV_LAST;
        end
        OP_DIV_STEP: begin
          if (!diff[11]) begin
            rem_r <= diff[9:0];
            quo_r <= {quo_r[24:0], 1'b1};
          end else begin
            rem_r <= {rem_r[8:0], quo_r[25]};
            quo_r <= {quo_r[24:0], 1'b0};
          end
          cnt_r <= 5'(cnt_r - 5'd1);
        end
        OP_INST_QUO:  inst_r <= sat_quo;
        OP_INST_PROD: inst_r <= sat_prod;
        OP_EMA_MUL: begin
          pa_r <= {10'd0, avg_r} * {16'd0, EMA_OLD_WEIGHT};
          pb_r <= {9'd0, inst_r} * {15'd0, EMA_NEW_WEIGHT};
        end
        OP_EMA_SUM:   quo_r <= ema_sum;
        OP_EMA_RECIP: ema_quo_r <= ema_recip[EMA_RECIP_SHIFT+15:EMA_RECIP_SHIFT];
        OP_EMIT_AVG:  out_speed_r <= ema_quo_r;
        OP_EMIT_SEED: out_speed_r <= sat_prod;
        default: ;
      endcase
    end
  end

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    take |=> (step_r == ST_MUL))
    else $error("accepted transaction did not start the program");

  a_div_remainder: assert property (@(posedge clk) disable iff (!rst_n)
    (step_r == ST_INST_QUO) |-> (rem_r < div_r))
    else $error("divider remainder not below divisor");

  a_result_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_valid_r ##1 out_valid_r) |->
      (($past(step_r) == ST_EMIT_AVG) || ($past(step_r) == ST_EMIT_SEED)))
    else $error("result raised outside an emit step");

  a_ready_only_at_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.ready |-> (step_r == ST_ACCEPT))
    else $error("input ready outside the accept step");

endmodule
`default_nettype wire

/* dv/pse_speed_monitor.sv */
// Monitor that predicts every smoothed speed estimate and compares it with the result channel.
module pse_speed_monitor
  import pse_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  pse_in_if                          in_ch,
  pse_out_if                         out_ch,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  output int unsigned                mismatches,
  output int unsigned                outstanding,
  output int unsigned                speeds_checked,
  output int unsigned                seeded_events,
  output int unsigned                short_gap_events,
  output int unsigned                long_gap_events
);

  localparam logic [31:0] SPEED_CEIL = 32'd65535;

  logic [SCALE_W-1:0] speed_scale = SPEED_SCALE_RESET;
  logic [MAXIN_W-1:0] max_input = MAX_INPUT_RESET;
  logic [31:0]        last_time = '0;
  logic [15:0]        avg_speed = '0;
  logic [15:0]        speed_q[$];
  logic [15:0]        want_speed;
  int unsigned        n_bad = 0;
  int unsigned        n_checked = 0;
  int unsigned        n_seed = 0;
  int unsigned        n_short = 0;
  int unsigned        n_long = 0;

  function automatic logic [15:0] clip16(input logic [31:0] v);
    return (v > SPEED_CEIL) ? 16'hFFFF : v[15:0];
  endfunction

  // Updates the stored time and average for one transaction and returns the reported speed.
  function automatic logic [15:0] advance_estimate(input logic [15:0] movement,
                                                   input logic [31:0] now_ms);
    logic [31:0] mag;
    logic [31:0] gap;
    logic [31:0] instant;
    logic [31:0] blend;
    mag = movement[15] ? (32'h0001_0000 - {16'h0, movement}) : {16'h0, movement};
    if (mag > {17'h0, max_input}) mag = {17'h0, max_input};
    if (last_time == 32'h0 || now_ms < last_time) begin
      n_seed++;
      last_time = now_ms;
      avg_speed = clip16(mag * {22'h0, speed_scale});
      return avg_speed;
    end
    gap = now_ms - last_time;
    if (gap != 32'h0 && gap < {22'h0, MS_PER_SECOND}) begin
      n_short++;
      instant = {16'h0, clip16((mag * {22'h0, MS_PER_SECOND}) / gap)};
    end else begin
      n_long++;
      instant = {16'h0, clip16(mag * {22'h0, speed_scale})};
    end
    blend = ({16'h0, avg_speed} * {22'h0, EMA_OLD_WEIGHT} +
             instant * {22'h0, EMA_NEW_WEIGHT}) / {22'h0, EMA_TOTAL};
    avg_speed = blend[15:0];
    last_time = now_ms;
    return avg_speed;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      speed_scale = SPEED_SCALE_RESET;
      max_input = MAX_INPUT_RESET;
      last_time = '0;
      avg_speed = '0;
      speed_q.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_SPEED_SCALE) begin
          speed_scale = cfg_data[SCALE_W-1:0];
        end else if (cfg_index == CFG_MAX_INPUT) begin
          max_input = cfg_data[MAXIN_W-1:0];
        end
      end
      if (out_ch.valid && out_ch.ready) begin
        if (speed_q.size() == 0) begin
          $error("speed %0d arrived with no event waiting for a result", out_ch.speed);
          n_bad++;
        end else begin
          want_speed = speed_q.pop_front();
          n_checked++;
          if (out_ch.speed !== want_speed) begin
            $error("speed mismatch: expected %0d, actual %0d", want_speed, out_ch.speed);
            n_bad++;
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        speed_q.push_back(advance_estimate(in_ch.movement, in_ch.now_ms));
      end
    end
    mismatches <= n_bad;
    outstanding <= speed_q.size();
    speeds_checked <= n_checked;
    seeded_events <= n_seed;
    short_gap_events <= n_short;
    long_gap_events <= n_long;
  end

endmodule

/* dv/tb_pointer_speed_estimator.sv */
// Testbench top that drives the pointer speed estimator and reports the verdict.
module tb_pointer_speed_estimator;
  import pse_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 500000;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned RANDOM_PHASES = 8;
  localparam int unsigned EVENTS_PER_PHASE = 100;
  localparam int unsigned SETTLE_CYCLES = 80;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_SPEED_SCALE;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  hold_start = 1'b0;
  logic [31:0]           clock_ms = '0;
  int unsigned           in_idle_pct = 0;
  int unsigned           out_stall_pct = 0;
  int unsigned           hold_left = 0;
  int unsigned           cycle_count = 0;
  int unsigned           events_sent = 0;
  int unsigned           mismatches;
  int unsigned           outstanding;
  int unsigned           speeds_checked;
  int unsigned           seeded_events;
  int unsigned           short_gap_events;
  int unsigned           long_gap_events;

  pse_in_if  in_ch();
  pse_out_if out_ch();

  always #10 clk = ~clk;

  pointer_speed_estimator dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  pse_speed_monitor speed_monitor (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_ch            (in_ch),
    .out_ch           (out_ch),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .mismatches       (mismatches),
    .outstanding      (outstanding),
    .speeds_checked   (speeds_checked),
    .seeded_events    (seeded_events),
    .short_gap_events (short_gap_events),
    .long_gap_events  (long_gap_events)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles.", cycle_count);
      $display("pointer_speed_estimator verification failed");
      $finish;
    end
  end

  // A long hold-off lets the block fill up and stall its input.
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_start) begin
        hold_left = HOLD_CYCLES;
        out_ch.ready <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= out_stall_pct);
      end
    end
  end

  task automatic send_event(input logic [15:0] movement, input logic [31:0] now_ms);
    while ($urandom_range(99) < in_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.movement <= movement;
    in_ch.now_ms <= now_ms;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    events_sent++;
    clock_ms = now_ms;
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic write_regs(input logic [SCALE_W-1:0] scale, input logic [MAXIN_W-1:0] limit);
    cfg_we <= 1'b1;
    cfg_index <= CFG_SPEED_SCALE;
    cfg_data <= CFG_DATA_W'(scale);
    @(posedge clk);
    cfg_index <= CFG_MAX_INPUT;
    cfg_data <= limit;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [SCALE_W-1:0] pick_scale();
    case ($urandom_range(5))
      0: return '0;
      1: return 10'd1;
      2: return 10'd1000;
      3: return '1;
      default: return SCALE_W'($urandom_range(1, 1000));
    endcase
  endfunction

  function automatic logic [MAXIN_W-1:0] pick_max_input();
    case ($urandom_range(5))
      0: return '0;
      1: return 15'd1;
      2: return '1;
      3: return MAXIN_W'($urandom_range(1, 300));
      default: return MAXIN_W'($urandom_range(1, 32767));
    endcase
  endfunction

  function automatic logic [15:0] pick_movement();
    int unsigned sel;
    logic [15:0] m;
    sel = $urandom_range(9);
    if (sel < 2) begin
      m = 16'($urandom);
    end else if (sel < 3) begin
      case ($urandom_range(3))
        0: m = 16'h7FFF;
        1: m = 16'h8000;
        2: m = 16'hFFFF;
        default: m = 16'h0000;
      endcase
    end else if (sel < 7) begin
      m = 16'($urandom_range(200));
    end else begin
      m = 16'($urandom_range(4000));
    end
    if (sel >= 3 && $urandom_range(1) == 1) m = -m;
    return m;
  endfunction

  // Mostly steadily rising timestamps, with repeats, long gaps, backward jumps and zeros.
  function automatic logic [31:0] pick_time(input logic [31:0] prev);
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 50) return prev + $urandom_range(1, 999);
    if (sel < 62) return prev + $urandom_range(1, 20);
    if (sel < 70) return prev;
    if (sel < 82) return prev + $urandom_range(1000, 200000);
    if (sel < 90) return prev - $urandom_range(1, 5000);
    if (sel < 94) return 32'd0;
    return $urandom;
  endfunction

  initial begin
    in_ch.valid = 1'b0;
    in_ch.movement = '0;
    in_ch.now_ms = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_event(16'd5, 32'd100);
    send_event(-16'sd20, 32'd110);
    send_event(16'd7, 32'd110);
    send_event(16'h7FFF, 32'd1110);
    send_event(16'h8000, 32'd2109);
    send_event(16'd1000, 32'd2110);
    send_event(16'd3, 32'd50);
    send_event(16'd100, 32'd0);
    send_event(16'd9, 32'd0);
    send_event(16'hFFFF, 32'hFFFF_FFFF);
    send_event(16'd2, 32'd0);
    send_event(16'd0, 32'd5);
    send_event(16'd500, 32'h8000_0005);
    send_event(-16'sd500, 32'h8000_0006);
    drain();
    write_regs('0, '0);
    send_event(16'd123, 32'h8000_000B);
    send_event(16'h8000, 32'h8000_0800);
    drain();
    write_regs('1, '1);
    send_event(16'h8000, 32'h8000_0803);
    send_event(16'h7FFF, 32'h8000_0803);
    send_event(16'd100, 32'h8000_1000);
    drain();
    write_regs(10'd1000, 15'd1);
    send_event(-16'sd5, 32'h8000_1007);
    drain();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p % 4)
        0: begin
          in_idle_pct = 0;
          out_stall_pct = 0;
        end
        1: begin
          in_idle_pct = 79;
          out_stall_pct = 0;
        end
        2: begin
          in_idle_pct = 0;
          out_stall_pct = 79;
        end
        default: begin
          in_idle_pct = 36;
          out_stall_pct = 36;
        end
      endcase
      write_regs(pick_scale(), pick_max_input());
      if (p == 0) begin
        hold_start <= 1'b1;
        @(posedge clk);
        hold_start <= 1'b0;
      end
      clock_ms = $urandom;
      repeat (EVENTS_PER_PHASE) send_event(pick_movement(), pick_time(clock_ms));
      drain();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Sent %0d movement events and checked %0d speed estimates across %0d settings.",
             events_sent, speeds_checked, RANDOM_PHASES + 4);
    $display("Seeded estimates: %0d, gaps of 1 to 999 ms: %0d, zero or long gaps: %0d.",
             seeded_events, short_gap_events, long_gap_events);
    if (mismatches == 0) begin
      $display("pointer_speed_estimator verification clean");
    end else begin
      $display("pointer_speed_estimator verification failed");
    end
    $finish;
  end

endmodule

/* pointer_speed_estimator.f */
sv/pse_pkg.sv
sv/pse_in_if.sv
sv/pse_out_if.sv
sv/pointer_speed_estimator.sv
dv/pse_speed_monitor.sv
dv/tb_pointer_speed_estimator.sv
